[hw/rtl/sdtq_pkg.sv]
// Shared constants and types for the sorted deadline timer queue.
package sdtq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
    localparam int MAX_OUT     = 16;
    localparam int NOUT_W      = $clog2(MAX_OUT + 1);

    localparam logic [1:0] FUNC_ARM    = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [2:0] ST_ARMED     = 3'd0;
    localparam logic [2:0] ST_CANCELLED = 3'd1;
    localparam logic [2:0] ST_NOTFOUND  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EXPIRED   = 3'd4;
    localparam logic [2:0] ST_NOEXP     = 3'd5;

    typedef struct packed {
        logic [31:0] deadline;
        logic [15:0] id;
        logic [31:0] tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic        last;
        logic [2:0]  status;
        logic [31:0] ticks_to_next;
        logic [31:0] result_tag;
        logic [15:0] result_id;
    } out_word_t;

endpackage

[hw/rtl/sdtq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module sdtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/sdtq_out.sv]
// Output word register on the master-side stream.
module sdtq_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  sdtq_pkg::out_word_t   word,
    output logic                  can_load,
    output logic                  tvalid,
    input  logic                  tready,
    output logic [79:0]           tdata,   // result_id, result_tag, ticks_to_next
    output logic [2:0]            tuser,   // status
    output logic                  tlast
);
    import sdtq_pkg::*;

    logic      valid_reg;
    out_word_t word_reg;

    assign can_load = !valid_reg || tready;
    assign tvalid   = valid_reg;
    assign tdata    = {word_reg.ticks_to_next, word_reg.result_tag, word_reg.result_id};
    assign tuser    = word_reg.status;
    assign tlast    = word_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word;
        end
    end

endmodule

[hw/rtl/sorted_deadline_timer_queue_unit.sv]
// Top level: sequencer of the sorted deadline timer queue over an entry RAM.
//
// Input stream (s_axis): one word per operation; tuser carries the function
// (arm, cancel, tick), tdata carries delay_ticks, user_tag and timer_id.
// Output stream (m_axis): one word per arm or cancel, one to sixteen per tick;
// tuser carries the status, tlast marks the final word of an operation.
// Entries sit in one RAM ordered by deadline, position 0 the earliest. Each
// entry visit is a RAM read, then a check or write back. The longest
// operation is a tick that expires a full pool, plus any receiver stalls.
// One operation is worked on at a time; s_axis_tready is high only between
// operations. The final word waits in the output register, so the next
// operation is taken while it is pending. A stalled receiver holds the
// sequencer when a further word must be issued.
// Reset clears the time counter, the id counter (to one) and the fill count;
// the RAM needs no clearing since only data read from positions below the count is used.
module sorted_deadline_timer_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // delay_ticks, user_tag, timer_id, zero pad
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // result_id, result_tag, ticks_to_next
    output logic [2:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast
);
    import sdtq_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ARM_RD   = 4'd1;
    localparam logic [3:0] S_ARM_CHK  = 4'd2;
    localparam logic [3:0] S_SHD_RD   = 4'd3;
    localparam logic [3:0] S_SHD_WR   = 4'd4;
    localparam logic [3:0] S_CAN_RD   = 4'd5;
    localparam logic [3:0] S_CAN_CHK  = 4'd6;
    localparam logic [3:0] S_SHU_RD   = 4'd7;
    localparam logic [3:0] S_SHU_WR   = 4'd8;
    localparam logic [3:0] S_HEAD_RD  = 4'd9;
    localparam logic [3:0] S_HEAD_CHK = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [31:0]       now_reg, now_next;
    logic [15:0]       nid_reg, nid_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [NOUT_W-1:0] n_reg, n_next;
    logic              tick_reg, tick_next;
    logic              held_reg, held_next;
    logic [19:0]       delay_reg, delay_next;
    logic [31:0]       tag_reg, tag_next;
    logic [15:0]       want_reg, want_next;
    logic [2:0]        rs_reg, rs_next;
    logic [15:0]       rid_reg, rid_next;
    logic [31:0]       rtag_reg, rtag_next;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic [SLOT_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_raw;
    entry_t            rd_ent;

    logic              out_load, out_can;
    out_word_t         out_word;

    logic [31:0]       diff, since, ttn;
    logic              head_passed;
    logic [CNT_W-1:0]  idx_dec, idx_inc;
    logic [15:0]       nid_inc;

    assign rd_ent  = entry_t'(rd_raw);
    assign diff    = rd_ent.deadline - now_reg;
    assign since   = now_reg - rd_ent.deadline;
    assign head_passed = !since[31];
    assign idx_dec = idx_reg - 1'b1;
    assign idx_inc = idx_reg + 1'b1;
    assign nid_inc = nid_reg + 16'd1;

    always_comb
    begin
        if (count_reg == '0)
        begin
            ttn = '1;
        end
        else if (head_passed)
        begin
            ttn = '0;
        end
        else
        begin
            ttn = diff;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    sdtq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TIMER_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    sdtq_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .word     (out_word),
        .can_load (out_can),
        .tvalid   (m_axis_tvalid),
        .tready   (m_axis_tready),
        .tdata    (m_axis_tdata),
        .tuser    (m_axis_tuser),
        .tlast    (m_axis_tlast)
    );

    always_comb
    begin
        state_next = state_reg;
        now_next   = now_reg;
        nid_next   = nid_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        tick_next  = tick_reg;
        held_next  = held_reg;
        delay_next = delay_reg;
        tag_next   = tag_reg;
        want_next  = want_reg;
        rs_next    = rs_reg;
        rid_next   = rid_reg;
        rtag_next  = rtag_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[SLOT_W-1:0];
        wr_data    = rd_ent;
        rd_addr    = '0;
        out_load   = 1'b0;
        out_word   = '{last: 1'b1, status: rs_reg, ticks_to_next: ttn,
                       result_tag: rtag_reg, result_id: rid_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    delay_next = s_axis_tdata[19:0];
                    tag_next   = s_axis_tdata[51:20];
                    want_next  = s_axis_tdata[67:52];
                    pos_next   = '0;
                    tick_next  = 1'b0;
                    rtag_next  = '0;
                    unique case (s_axis_tuser)
                        FUNC_ARM:
                        begin
                            if (count_reg == CNT_W'(TIMER_SLOTS))
                            begin
                                rs_next    = ST_FULL;
                                rid_next   = '0;
                                state_next = S_HEAD_RD;
                            end
                            else
                            begin
                                state_next = S_ARM_RD;
                            end
                        end
                        FUNC_CANCEL:
                        begin
                            state_next = S_CAN_RD;
                        end
                        FUNC_TICK:
                        begin
                            now_next   = now_reg + 32'd1;
                            tick_next  = 1'b1;
                            held_next  = 1'b0;
                            n_next     = '0;
                            rs_next    = ST_NOEXP;
                            rid_next   = '0;
                            state_next = S_HEAD_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ARM_RD:
            begin
                rd_addr = pos_reg[SLOT_W-1:0];
                if (pos_reg == count_reg)
                begin
                    idx_next   = count_reg;
                    state_next = S_SHD_RD;
                end
                else
                begin
                    state_next = S_ARM_CHK;
                end
            end
            S_ARM_CHK:
            begin
                if (!(diff[31] || diff <= {12'd0, delay_reg}))
                begin
                    idx_next   = count_reg;
                    state_next = S_SHD_RD;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_ARM_RD;
                end
            end
            S_SHD_RD:
            begin
                rd_addr = idx_dec[SLOT_W-1:0];
                if (idx_reg == pos_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[SLOT_W-1:0];
                    wr_data    = '{deadline: now_reg + {12'd0, delay_reg},
                                   id: nid_reg, tag: tag_reg};
                    count_next = count_reg + 1'b1;
                    nid_next   = (nid_inc == '0) ? 16'd1 : nid_inc;
                    rs_next    = ST_ARMED;
                    rid_next   = nid_reg;
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    state_next = S_SHD_WR;
                end
            end
            S_SHD_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[SLOT_W-1:0];
                idx_next   = idx_dec;
                state_next = S_SHD_RD;
            end
            S_CAN_RD:
            begin
                rd_addr = pos_reg[SLOT_W-1:0];
                if (pos_reg == count_reg)
                begin
                    rs_next    = ST_NOTFOUND;
                    rid_next   = want_reg;
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    state_next = S_CAN_CHK;
                end
            end
            S_CAN_CHK:
            begin
                if (rd_ent.id == want_reg)
                begin
                    rs_next    = ST_CANCELLED;
                    rid_next   = want_reg;
                    idx_next   = pos_reg;
                    state_next = S_SHU_RD;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_CAN_RD;
                end
            end
            S_SHU_RD:
            begin
                rd_addr = idx_inc[SLOT_W-1:0];
                if (idx_inc >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    state_next = S_SHU_WR;
                end
            end
            S_SHU_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[SLOT_W-1:0];
                idx_next   = idx_inc;
                state_next = S_SHU_RD;
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_CHK;
            end
            S_HEAD_CHK:
            begin
                if (tick_reg && count_reg != '0 && head_passed
                    && n_reg < NOUT_W'(MAX_OUT))
                begin
                    if (!held_reg || out_can)
                    begin
                        out_word.last          = 1'b0;
                        out_word.ticks_to_next = '0;
                        out_load   = held_reg;
                        held_next  = 1'b1;
                        rs_next    = ST_EXPIRED;
                        rid_next   = rd_ent.id;
                        rtag_next  = rd_ent.tag;
                        n_next     = n_reg + 1'b1;
                        idx_next   = '0;
                        state_next = S_SHU_RD;
                    end
                end
                else if (out_can)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            now_reg   <= '0;
            nid_reg   <= 16'd1;
            count_reg <= '0;
            held_reg  <= 1'b0;
            tick_reg  <= 1'b0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg   <= now_next;
            nid_reg   <= nid_next;
            count_reg <= count_next;
            held_reg  <= held_next;
            tick_reg  <= tick_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        idx_reg   <= idx_next;
        delay_reg <= delay_next;
        tag_reg   <= tag_next;
        want_reg  <= want_next;
        rs_reg    <= rs_next;
        rid_reg   <= rid_next;
        rtag_reg  <= rtag_next;
    end

endmodule

[tb/sorted_deadline_timer_queue_unit_tb.sv]
// Testbench for the sorted deadline timer queue, checked against a local predictor.
`timescale 1ns / 1ps

module sorted_deadline_timer_queue_unit_tb;
    import sdtq_pkg::*;

    typedef struct {
        logic [1:0]  func;
        logic [19:0] delay;
        logic [31:0] tag;
        logic [15:0] id;
    } op_t;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] rid;
        logic [31:0] rtag;
        logic [31:0] ttn;
        logic        last;
    } res_t;

    localparam int LIMIT = 2000000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    op_t  pending_ops[$];
    res_t expected_words[$];
    int   mismatches;
    int   cycles;
    int   hold_off;
    bit   feeding_done;

    // predictor state
    logic [31:0] now_ticks;
    logic [15:0] next_id;
    logic [31:0] dl[TIMER_SLOTS];
    logic [15:0] tid[TIMER_SLOTS];
    logic [31:0] ttag[TIMER_SLOTS];
    int          order[$];
    bit          busy_slot[TIMER_SLOTS];
    logic [15:0] live_ids[$];

    sorted_deadline_timer_queue_unit i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] next_deadline_gap();
        logic [31:0] d;
        if (order.size() == 0)
            return 32'hFFFF_FFFF;
        d = dl[order[0]];
        if (((now_ticks - d) & 32'h8000_0000) == 0)
            return 32'd0;
        return d - now_ticks;
    endfunction

    function automatic void push_word(logic [2:0] st, logic [15:0] rid, logic [31:0] rtag,
                                      logic [31:0] ttn, logic last);
        res_t r;
        r.status = st;
        r.rid = rid;
        r.rtag = rtag;
        r.ttn = ttn;
        r.last = last;
        expected_words.push_back(r);
    endfunction

    function automatic void predict_timer_op(op_t op);
        int s;
        int p;
        int n;
        logic [31:0] diff;
        case (op.func)
            FUNC_ARM:
            begin
                s = -1;
                for (int i = 0; i < TIMER_SLOTS; i++)
                    if (s < 0 && !busy_slot[i])
                        s = i;
                if (order.size() >= TIMER_SLOTS || s < 0)
                begin
                    push_word(ST_FULL, 16'd0, 32'd0, next_deadline_gap(), 1'b1);
                    return;
                end
                for (p = 0; p < order.size(); p++)
                begin
                    diff = dl[order[p]] - now_ticks;
                    if (!(diff[31] || diff <= {12'd0, op.delay}))
                        break;
                end
                order.insert(p, s);
                busy_slot[s] = 1'b1;
                dl[s] = now_ticks + {12'd0, op.delay};
                tid[s] = next_id;
                ttag[s] = op.tag;
                live_ids.push_back(next_id);
                push_word(ST_ARMED, next_id, 32'd0, next_deadline_gap(), 1'b1);
                next_id = next_id + 16'd1;
                if (next_id == 16'd0)
                    next_id = 16'd1;
            end
            FUNC_CANCEL:
            begin
                for (p = 0; p < order.size(); p++)
                    if (tid[order[p]] == op.id)
                        break;
                if (p >= order.size())
                    push_word(ST_NOTFOUND, op.id, 32'd0, next_deadline_gap(), 1'b1);
                else
                begin
                    busy_slot[order[p]] = 1'b0;
                    order.delete(p);
                    push_word(ST_CANCELLED, op.id, 32'd0, next_deadline_gap(), 1'b1);
                end
            end
            FUNC_TICK:
            begin
                now_ticks = now_ticks + 32'd1;
                n = 0;
                while (n < MAX_OUT && order.size() > 0)
                begin
                    s = order[0];
                    if (((now_ticks - dl[s]) & 32'h8000_0000) != 0)
                        break;
                    busy_slot[s] = 1'b0;
                    void'(order.pop_front());
                    push_word(ST_EXPIRED, tid[s], ttag[s], 32'd0, 1'b0);
                    n++;
                end
                if (n == 0)
                    push_word(ST_NOEXP, 16'd0, 32'd0, next_deadline_gap(), 1'b1);
                else
                begin
                    expected_words[expected_words.size() - 1].ttn = next_deadline_gap();
                    expected_words[expected_words.size() - 1].last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void add_op(logic [1:0] f, logic [19:0] d, logic [31:0] t, logic [15:0] i);
        op_t op;
        op.func = f;
        op.delay = d;
        op.tag = t;
        op.id = i;
        pending_ops.push_back(op);
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // driver
    int src_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            src_gap       <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                predict_timer_op('{s_axis_tuser, s_axis_tdata[19:0], s_axis_tdata[51:20],
                                   s_axis_tdata[67:52]});
            if (src_gap > 0 || pending_ops.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if (src_gap > 0)
                    src_gap <= src_gap - 1;
            end
            else
            begin
                op_t op;
                op = pending_ops.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= op.func;
                s_axis_tdata  <= {4'd0, op.id, op.tag, op.delay};
                src_gap       <= gap_len();
            end
        end
    end

    // receiver stall and monitor
    int sink_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
            mismatches    <= 0;
            cycles        <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected word: status %0d id %0h", m_axis_tuser,
                                 m_axis_tdata[15:0]);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    res_t e;
                    e = expected_words.pop_front();
                    if (e.status !== m_axis_tuser || e.rid !== m_axis_tdata[15:0] ||
                        e.rtag !== m_axis_tdata[47:16] || e.ttn !== m_axis_tdata[79:48] ||
                        e.last !== m_axis_tlast)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch: exp st %0d id %0h tag %0h ttn %0h last %0b",
                                      " / got st %0d id %0h tag %0h ttn %0h last %0b"},
                                     e.status, e.rid, e.rtag, e.ttn, e.last, m_axis_tuser,
                                     m_axis_tdata[15:0], m_axis_tdata[47:16],
                                     m_axis_tdata[79:48], m_axis_tlast);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (hold_off > 0)
                m_axis_tready <= 1'b0;
            else if (sink_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    sink_gap <= gap_len();
            end
        end
    end

    // long receiver hold-off
    initial
    begin
        hold_off = 0;
        wait (rst_n);
        repeat (3000) @(posedge clk);
        hold_off = 400;
        while (hold_off > 0)
        begin
            @(posedge clk);
            hold_off = hold_off - 1;
        end
    end

    initial
    begin
        int k;
        logic [1:0] f;
        now_ticks = 32'd0;
        next_id = 16'd1;
        for (int i = 0; i < TIMER_SLOTS; i++)
            busy_slot[i] = 1'b0;
        rst_n = 1'b0;

        // directed: extremes, equal deadlines, fill to full, cancels, multi-expiry
        add_op(FUNC_TICK, 20'd0, 32'd0, 16'd0);
        add_op(FUNC_CANCEL, 20'd0, 32'd0, 16'hFFFF);
        add_op(FUNC_CANCEL, 20'd0, 32'd0, 16'h0000);
        add_op(FUNC_ARM, 20'hFFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_op(FUNC_ARM, 20'd0, 32'h0000_0000, 16'd0);
        add_op(FUNC_TICK, 20'd0, 32'd0, 16'd0);
        for (int i = 0; i < 17; i++)
            add_op(FUNC_ARM, 20'd2, 32'hA5A5_0000 + 32'(i), 16'd0);
        add_op(FUNC_CANCEL, 20'd0, 32'd0, 16'd3);
        add_op(FUNC_UNUSED, 20'hFFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_op(FUNC_TICK, 20'd0, 32'd0, 16'd0);
        add_op(FUNC_TICK, 20'd0, 32'd0, 16'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < 313; k++)
        begin
            wait (pending_ops.size() < 4);
            f = $urandom_range(0, 99) < 40 ? FUNC_ARM :
                ($urandom_range(0, 1) ? FUNC_TICK : FUNC_CANCEL);
            if ($urandom_range(0, 49) == 0)
                f = FUNC_UNUSED;
            if (f == FUNC_CANCEL && live_ids.size() > 0 && $urandom_range(0, 3) != 0)
                add_op(f, 20'($urandom), $urandom,
                       live_ids[$urandom_range(0, live_ids.size() - 1)]);
            else
                add_op(f, ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(0, 12)),
                       $urandom, 16'($urandom));
            @(posedge clk);
        end
        // end with ticks to expire the timers that fall due
        for (k = 0; k < 20; k++)
            add_op(FUNC_TICK, 20'($urandom), $urandom, 16'($urandom));
        wait (pending_ops.size() == 0 && !s_axis_tvalid);
        feeding_done = 1'b1;
    end

    initial
    begin
        feeding_done = 1'b0;
        wait (rst_n);
        while (!(feeding_done && expected_words.size() == 0) && cycles < LIMIT)
            @(posedge clk);
        if (cycles >= LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            repeat (100) @(posedge clk);
            if (mismatches == 0 && expected_words.size() == 0)
                $display("PASS");
            else
                $display("FAIL");
            $finish;
        end
    end

endmodule
